/* rtl/core/tdmss_pkg.sv */
// ----------------------------------------------------------------------------
// tdmss_pkg
// Shared types and constants of the TDM microphone slot selector.
// ----------------------------------------------------------------------------
package tdmss_pkg;

  localparam int NUM_SLOTS   = 4;
  localparam int SLOT_W      = 2;
  localparam int SAMPLE_W    = 16;
  localparam int MAG_W       = SAMPLE_W + 1;
  localparam int ENERGY_W    = 22;
  localparam int LEVEL_W     = 16;
  localparam int STABLE_W    = 8;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;
  localparam int FRAME_W     = NUM_SLOTS * SAMPLE_W;

  typedef logic [SLOT_W-1:0]          slot_t;
  typedef logic [ENERGY_W-1:0]        energy_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [LEVEL_W-1:0]         level_t;
  typedef logic [STABLE_W-1:0]        stable_t;
  typedef logic [FRAME_W-1:0]         frame_t;

  localparam slot_t   PAIR_LO_DEFAULT = 2'd0;
  localparam slot_t   PAIR_HI_DEFAULT = 2'd1;
  localparam stable_t STABLE_MAX      = 8'hFF;
  localparam level_t  LEVEL_RESET     = 16'd32;
  localparam stable_t STABLE_RESET    = 8'd3;

  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_LEVEL = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_STABLE    = 8'd1;

  // result of the slot ranking, valid for one cycle with done
  typedef struct packed {
    logic  done;
    slot_t lo;
    slot_t hi;
    logic  level_ok;
  } mrg_res_t;

endpackage

/* rtl/core/tdmss_lane.sv */
// ----------------------------------------------------------------------------
// tdmss_lane
// One slot lane: sums the absolute value of the slot's samples over a block.
// ----------------------------------------------------------------------------
module tdmss_lane
  import tdmss_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    clr_i,
  input  logic    acc_i,
  input  sample_t sample_i,
  output energy_t energy_o
);

  logic [MAG_W-1:0] ext;
  logic [MAG_W-1:0] mag;
  energy_t          energy_d, energy_q;

  assign ext = {sample_i[SAMPLE_W-1], sample_i};
  assign mag = sample_i[SAMPLE_W-1] ? (MAG_W'(0) - ext) : ext;

  always_comb begin
    energy_d = energy_q;
    if (clr_i) begin
      energy_d = '0;
    end else if (acc_i) begin
      energy_d = energy_q + ENERGY_W'(mag);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      energy_q <= '0;
    end else begin
      energy_q <= energy_d;
    end
  end

  assign energy_o = energy_q;

endmodule

/* rtl/core/tdmss_merge.sv */
// ----------------------------------------------------------------------------
// tdmss_merge
// Ranks the lane energies: strongest, then second strongest slot, then the
// average level check of the second slot against the programmed floor.
// ----------------------------------------------------------------------------
module tdmss_merge
  import tdmss_pkg::*;
#(
  parameter int MAX_FRAMES = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  energy_t                              energy_i [NUM_SLOTS],
  input  logic [$clog2(MAX_FRAMES+1)-1:0]      count_i,
  input  level_t                               min_level_i,
  output mrg_res_t                             res_o
);

  localparam int CW   = $clog2(MAX_FRAMES + 1);
  localparam int PW   = LEVEL_W + CW;
  localparam int CMPW = (PW > ENERGY_W) ? PW : ENERGY_W;

  slot_t         str_d, str_q;
  slot_t         sec_d;
  logic [PW-1:0] prod_q, prod2_q;
  energy_t       e2_q;
  logic          s1_valid_q, s2_valid_q, done_q;
  slot_t         lo_q, hi_q, lo3_q, hi3_q;
  logic          level_ok_q;

  // stage 1: strongest slot, lower index wins ties
  always_comb begin
    str_d = '0;
    for (int s = 1; s < NUM_SLOTS; s++) begin
      if (energy_i[s] > energy_i[str_d]) begin
        str_d = SLOT_W'(s);
      end
    end
  end

  // stage 2: second strongest slot
  always_comb begin
    sec_d = (str_q == '0) ? SLOT_W'(1) : SLOT_W'(0);
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if ((SLOT_W'(s) != str_q) && (energy_i[s] > energy_i[sec_d])) begin
        sec_d = SLOT_W'(s);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      s1_valid_q <= start_i;
      s2_valid_q <= s1_valid_q;
      done_q     <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      str_q  <= str_d;
      prod_q <= PW'(min_level_i) * PW'(count_i);
    end
    if (s1_valid_q) begin
      lo_q    <= (str_q < sec_d) ? str_q : sec_d;
      hi_q    <= (str_q < sec_d) ? sec_d : str_q;
      e2_q    <= energy_i[sec_d];
      prod2_q <= prod_q;
    end
    if (s2_valid_q) begin
      lo3_q      <= lo_q;
      hi3_q      <= hi_q;
      // floor(e / n) >= m  <=>  e >= m * n
      level_ok_q <= CMPW'(e2_q) >= CMPW'(prod2_q);
    end
  end

  assign res_o.done     = done_q;
  assign res_o.lo       = lo3_q;
  assign res_o.hi       = hi3_q;
  assign res_o.level_ok = level_ok_q;

endmodule

/* rtl/core/tdmss_frame_buf.sv */
// ----------------------------------------------------------------------------
// tdmss_frame_buf
// Frame memory of one block and the read pipeline that plays it out as
// stereo results through a registered output stage.
// ----------------------------------------------------------------------------
module tdmss_frame_buf
  import tdmss_pkg::*;
#(
  parameter int MAX_FRAMES = 64
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    wr_en_i,
  input  logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] wr_addr_i,
  input  frame_t                                  wr_data_i,
  input  logic                                    start_i,
  input  logic [$clog2(MAX_FRAMES+1)-1:0]         count_i,
  input  slot_t                                   lo_i,
  input  slot_t                                   hi_i,
  input  logic                                    locked_i,
  output logic                                    busy_o,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output sample_t                                 left_o,
  output sample_t                                 right_o,
  output slot_t                                   first_o,
  output slot_t                                   second_o,
  output logic                                    locked_o,
  output logic                                    last_o
);

  localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CW = $clog2(MAX_FRAMES + 1);

  frame_t          mem [MAX_FRAMES];
  frame_t          rd_word_q;
  logic            emitting_q;
  logic [CW-1:0]   cnt_q, rd_cnt_q;
  slot_t           lo_q, hi_q;
  logic            locked_q;
  logic            s1_valid_q, s1_last_q;
  logic            out_valid_q;
  logic            out_move, s1_move, issue;

  assign out_move = !out_valid_q || out_ready_i;
  assign s1_move  = s1_valid_q && out_move;
  assign issue    = emitting_q && (rd_cnt_q != cnt_q) && (!s1_valid_q || s1_move);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (issue) begin
      rd_word_q <= mem[rd_cnt_q[AW-1:0]];
      s1_last_q <= CW'(rd_cnt_q + 1'b1) == cnt_q;
    end
    if (start_i) begin
      cnt_q    <= count_i;
      lo_q     <= lo_i;
      hi_q     <= hi_i;
      locked_q <= locked_i;
    end
    if (s1_move) begin
      left_o   <= rd_word_q[lo_q*SAMPLE_W +: SAMPLE_W];
      right_o  <= rd_word_q[hi_q*SAMPLE_W +: SAMPLE_W];
      first_o  <= lo_q;
      second_o <= hi_q;
      locked_o <= locked_q;
      last_o   <= s1_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emitting_q  <= 1'b0;
      rd_cnt_q    <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (start_i) begin
        emitting_q <= 1'b1;
        rd_cnt_q   <= '0;
      end else begin
        if (issue) begin
          rd_cnt_q <= rd_cnt_q + 1'b1;
        end
        if (emitting_q && (rd_cnt_q == cnt_q) && !s1_valid_q) begin
          emitting_q <= 1'b0;
        end
      end
      if (issue) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign busy_o      = emitting_q;
  assign out_valid_o = out_valid_q;

endmodule

/* rtl/core/tdm_mic_slot_selector.sv */
// ----------------------------------------------------------------------------
// tdm_mic_slot_selector
// Picks the two strongest of four TDM microphone slots per block, locks the
// pair once stable, and plays the block out as stereo pairs.
// ----------------------------------------------------------------------------
// Input stream: one request per TDM frame, four signed slot samples in
// s_axis_tdata, s_axis_tlast on the last frame of a block. A frame that fills
// the buffer (MAX_FRAMES) also ends the block.
// Frames are taken at one per cycle while a block is being collected. At the
// block end input is held off while four energy lanes are ranked (skipped
// once locked) and the whole block is read back from the frame memory, one
// result per cycle while the receiver is ready, through a memory read
// register and then a registered output stage.
// A stall on m_axis_tready holds the output and pauses the memory reads; input
// resumes once the read pipeline has drained after the last result of the block
// enters the output register, whether or not it has been taken yet.
// Config writes (cfg_valid_i/cfg_ready_o) are always taken; writing a known
// register resets detection and drops a partial block. Reset leaves the pair
// at slots 0 and 1, unlocked, with default registers and an empty buffer.
// ----------------------------------------------------------------------------
module tdm_mic_slot_selector
  import tdmss_pkg::*;
#(
  parameter int MAX_FRAMES = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // cfg request
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  // input frames
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [15:0] sample_slot_zero, [31:16] sample_slot_one,
  // [47:32] sample_slot_two, [63:48] sample_slot_three
  input  logic [63:0]            s_axis_tdata,
  input  logic                   s_axis_tlast,      // block_end
  // stereo results
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [15:0] left_sample, [31:16] right_sample, [33:32] first_slot,
  // [35:34] second_slot, [39:36] zero
  output logic [39:0]            m_axis_tdata,
  output logic                   m_axis_tuser,      // map_locked
  output logic                   m_axis_tlast       // last_of_block
);

  localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CW = $clog2(MAX_FRAMES + 1);

  typedef enum logic [2:0] {
    ST_COLLECT = 3'b001,
    ST_MERGE   = 3'b010,
    ST_EMIT    = 3'b100
  } state_e;

  state_e        state_d, state_q;
  logic [CW-1:0] frame_count_d, frame_count_q;
  slot_t         cand_lo_d, cand_lo_q, cand_hi_d, cand_hi_q;
  slot_t         act_lo_d, act_lo_q, act_hi_d, act_hi_q;
  stable_t       stable_d, stable_q;
  logic          locked_d, locked_q;
  level_t        min_level_q;
  stable_t       stable_need_q;
  logic          mrg_start_d, mrg_start_q;

  logic          cfg_acc, cfg_hit, in_acc, blk_end, go;
  energy_t       energy [NUM_SLOTS];
  mrg_res_t      mrg_res;
  logic          buf_busy;
  sample_t       left, right;
  slot_t         first, second;
  logic          out_locked, out_last;

  assign cfg_ready_o   = 1'b1;
  assign cfg_acc       = cfg_valid_i && cfg_ready_o;
  assign cfg_hit       = cfg_acc && ((cfg_index_i == CFG_MIN_LEVEL) ||
                                     (cfg_index_i == CFG_STABLE));
  assign s_axis_tready = (state_q == ST_COLLECT);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign blk_end       = in_acc && (s_axis_tlast || (frame_count_q == CW'(MAX_FRAMES - 1)));
  assign go            = (state_q == ST_MERGE) && (locked_q || mrg_res.done);

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_lane
    tdmss_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .clr_i    (cfg_hit || go),
      .acc_i    (in_acc && !locked_q),
      .sample_i (s_axis_tdata[g*SAMPLE_W +: SAMPLE_W]),
      .energy_o (energy[g])
    );
  end

  tdmss_merge #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (mrg_start_q),
    .energy_i    (energy),
    .count_i     (frame_count_q),
    .min_level_i (min_level_q),
    .res_o       (mrg_res)
  );

  always_comb begin
    state_d       = state_q;
    frame_count_d = frame_count_q;
    cand_lo_d     = cand_lo_q;
    cand_hi_d     = cand_hi_q;
    act_lo_d      = act_lo_q;
    act_hi_d      = act_hi_q;
    stable_d      = stable_q;
    locked_d      = locked_q;
    mrg_start_d   = 1'b0;
    case (state_q)
      ST_COLLECT: begin
        if (in_acc) begin
          frame_count_d = frame_count_q + 1'b1;
        end
        if (blk_end) begin
          state_d     = ST_MERGE;
          mrg_start_d = !locked_q;
        end
      end
      ST_MERGE: begin
        if (go) begin
          state_d       = ST_EMIT;
          frame_count_d = '0;
          if (!locked_q) begin
            if ((mrg_res.lo == cand_lo_q) && (mrg_res.hi == cand_hi_q)) begin
              if (stable_q != STABLE_MAX) begin
                stable_d = stable_q + 1'b1;
              end
            end else begin
              cand_lo_d = mrg_res.lo;
              cand_hi_d = mrg_res.hi;
              stable_d  = STABLE_W'(1);
            end
            act_lo_d = mrg_res.lo;
            act_hi_d = mrg_res.hi;
            if (mrg_res.level_ok && (stable_d >= stable_need_q)) begin
              locked_d = 1'b1;
            end
          end
        end
      end
      ST_EMIT: begin
        if (!buf_busy) begin
          state_d = ST_COLLECT;
        end
      end
      default: begin
        state_d = ST_COLLECT;
      end
    endcase
    if (cfg_hit) begin
      state_d       = ST_COLLECT;
      frame_count_d = '0;
      cand_lo_d     = PAIR_LO_DEFAULT;
      cand_hi_d     = PAIR_HI_DEFAULT;
      act_lo_d      = PAIR_LO_DEFAULT;
      act_hi_d      = PAIR_HI_DEFAULT;
      stable_d      = '0;
      locked_d      = 1'b0;
      mrg_start_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_COLLECT;
      frame_count_q <= '0;
      cand_lo_q     <= PAIR_LO_DEFAULT;
      cand_hi_q     <= PAIR_HI_DEFAULT;
      act_lo_q      <= PAIR_LO_DEFAULT;
      act_hi_q      <= PAIR_HI_DEFAULT;
      stable_q      <= '0;
      locked_q      <= 1'b0;
      mrg_start_q   <= 1'b0;
      min_level_q   <= LEVEL_RESET;
      stable_need_q <= STABLE_RESET;
    end else begin
      state_q       <= state_d;
      frame_count_q <= frame_count_d;
      cand_lo_q     <= cand_lo_d;
      cand_hi_q     <= cand_hi_d;
      act_lo_q      <= act_lo_d;
      act_hi_q      <= act_hi_d;
      stable_q      <= stable_d;
      locked_q      <= locked_d;
      mrg_start_q   <= mrg_start_d;
      if (cfg_acc && (cfg_index_i == CFG_MIN_LEVEL)) begin
        min_level_q <= cfg_data_i[LEVEL_W-1:0];
      end
      if (cfg_acc && (cfg_index_i == CFG_STABLE)) begin
        stable_need_q <= cfg_data_i[STABLE_W-1:0];
      end
    end
  end

  tdmss_frame_buf #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_frame_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (in_acc),
    .wr_addr_i   (frame_count_q[AW-1:0]),
    .wr_data_i   (s_axis_tdata),
    .start_i     (go),
    .count_i     (frame_count_q),
    .lo_i        (act_lo_d),
    .hi_i        (act_hi_d),
    .locked_i    (locked_d),
    .busy_o      (buf_busy),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .left_o      (left),
    .right_o     (right),
    .first_o     (first),
    .second_o    (second),
    .locked_o    (out_locked),
    .last_o      (out_last)
  );

  assign m_axis_tdata = {4'b0000, second, first, right, left};
  assign m_axis_tuser = out_locked;
  assign m_axis_tlast = out_last;

endmodule
